// ===== rtl/wdctp_pkg.sv =====
`default_nettype none

package wdctp_pkg;

    // Parse phase codes
    localparam logic [3:0] PH_LEAD      = 4'd0;
    localparam logic [3:0] PH_DAY       = 4'd1;
    localparam logic [3:0] PH_PRE_HOUR  = 4'd2;
    localparam logic [3:0] PH_HOUR      = 4'd3;
    localparam logic [3:0] PH_HOUR_JUNK = 4'd4;
    localparam logic [3:0] PH_PRE_MIN   = 4'd5;
    localparam logic [3:0] PH_MIN       = 4'd6;
    localparam logic [3:0] PH_MIN_JUNK  = 4'd7;
    localparam logic [3:0] PH_PRE_SEC   = 4'd8;
    localparam logic [3:0] PH_SEC       = 4'd9;
    localparam logic [3:0] PH_SEC_FRAC  = 4'd10;
    localparam logic [3:0] PH_SEC_JUNK  = 4'd11;
    localparam logic [3:0] PH_DONE      = 4'd12;

    // Character codes
    localparam logic [7:0] ASC_NUL   = 8'h00;
    localparam logic [7:0] ASC_TAB   = 8'h09;
    localparam logic [7:0] ASC_SPACE = 8'h20;
    localparam logic [7:0] ASC_DOT   = 8'h2E;
    localparam logic [7:0] ASC_0     = 8'h30;
    localparam logic [7:0] ASC_9     = 8'h39;
    localparam logic [7:0] ASC_COLON = 8'h3A;
    localparam logic [7:0] ASC_A     = 8'h41;
    localparam logic [7:0] ASC_Z     = 8'h5A;
    localparam logic [7:0] CASE_BIT  = 8'h20;

    // Millisecond weights and field limits
    localparam logic [29:0] DAY_MS  = 30'd86400000;
    localparam logic [29:0] HOUR_MS = 30'd3600000;
    localparam logic [29:0] MIN_MS  = 30'd60000;
    localparam logic [15:0] SEC_MS  = 16'd1000;
    localparam logic [7:0]  HOUR_MAX = 8'd23;
    localparam logic [7:0]  MIN_MAX  = 8'd59;
    localparam logic [7:0]  SEC_LIMIT = 8'd60;
    localparam logic [7:0]  ACCUM_MAX = 8'd255;
    localparam logic [6:0]  ALL_DAYS  = 7'h7F;

    // Parser fields that the end-of-text step works on
    typedef struct packed {
        logic [3:0]  phase;
        logic        err;
        logic [2:0]  day;
        logic [7:0]  accum;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [15:0] sec_ms;
    } parse_snap_t;

    localparam parse_snap_t SNAP_CLEAR = '{
        phase: PH_LEAD, err: 1'b0, day: 3'd0, accum: 8'd0,
        hour: 5'd0, minute: 6'd0, sec_ms: 16'd0
    };

    // Letter pos of the three-letter name of weekday d
    function automatic logic [7:0] day_letter(input logic [2:0] d, input logic [1:0] pos);
        logic [23:0] name;
        logic [7:0]  letter;
        case (d)
            3'd0:    name = "Sun";
            3'd1:    name = "Mon";
            3'd2:    name = "Tue";
            3'd3:    name = "Wed";
            3'd4:    name = "Thu";
            3'd5:    name = "Fri";
            3'd6:    name = "Sat";
            default: name = 24'd0;
        endcase
        case (pos)
            2'd0:    letter = name[23:16];
            2'd1:    letter = name[15:8];
            2'd2:    letter = name[7:0];
            default: letter = 8'd0;
        endcase
        return letter;
    endfunction

    // Fold upper case to lower case when enabled
    function automatic logic [7:0] fold_case(input logic [7:0] c, input logic en);
        logic [7:0] r;
        r = c;
        if (en && (c inside {[ASC_A:ASC_Z]}))
            r = c | CASE_BIT;
        return r;
    endfunction

    // Lowest day still set in the match mask
    function automatic logic [2:0] first_day(input logic [6:0] mask);
        logic [2:0] d;
        d = 3'd0;
        for (int i = 6; i >= 0; i--)
            if (mask[i])
                d = 3'(i);
        return d;
    endfunction

    // Append one decimal digit, saturating at 255
    function automatic logic [7:0] add_digit(input logic [7:0] acc, input logic [3:0] dig);
        logic [11:0] v;
        v = 12'(acc) * 12'd10 + 12'(dig);
        return (v > 12'(ACCUM_MAX)) ? ACCUM_MAX : v[7:0];
    endfunction

    // Weight of a fraction digit in ms
    function automatic logic [6:0] frac_weight(input logic [1:0] idx);
        logic [6:0] w;
        case (idx)
            2'd0:    w = 7'd100;
            2'd1:    w = 7'd10;
            default: w = 7'd1;
        endcase
        return w;
    endfunction

    function automatic parse_snap_t take_minute(input parse_snap_t s);
        parse_snap_t r;
        r = s;
        if (s.accum > MIN_MAX) begin
            r.err   = 1'b1;
            r.phase = PH_DONE;
        end
        else begin
            r.minute = s.accum[5:0];
            r.sec_ms = 16'd0;
            r.phase  = PH_PRE_SEC;
        end
        return r;
    endfunction

    function automatic parse_snap_t finish_seconds(input parse_snap_t s);
        parse_snap_t r;
        r = s;
        if (s.accum >= SEC_LIMIT)
            r.err = 1'b1;
        else
            r.sec_ms = s.sec_ms + 16'(s.accum) * SEC_MS;
        r.phase = PH_DONE;
        return r;
    endfunction

    // Close the text: settle pending fields or flag the error
    function automatic parse_snap_t end_of_text(input parse_snap_t s);
        parse_snap_t r;
        r = s;
        case (s.phase)
            PH_MIN, PH_MIN_JUNK:
            begin
                r = take_minute(s);
                r.phase = PH_DONE;
            end
            PH_PRE_SEC:
            begin
                r.sec_ms = 16'd0;
                r.phase  = PH_DONE;
            end
            PH_SEC, PH_SEC_FRAC, PH_SEC_JUNK:
            begin
                r = finish_seconds(s);
            end
            PH_DONE:
            begin
                r = s;
            end
            default:
            begin
                r.err   = 1'b1;
                r.phase = PH_DONE;
            end
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/weekday_clock_text_parser.sv =====
// Weekday clock text parser.
// Characters of "[Day] hh:mm[:ss[.fff]]" arrive on the slave stream, one per
// transaction, s_tdata = character code, s_tlast = final character. On the
// final character one result leaves on the master stream: m_tdata holds the
// time of week in ms (0 on error), m_tuser is the ok flag. Characters that
// are not last produce no result.
// Throughput: one character per cycle, set by the combinational parse step
// between the input register and the parser state registers.
// After the final character is accepted, the result passes through the
// input register, snapshot, end-of-text, partial sums and the final add
// into the output register.
// cfg_we/cfg_wdata write the weekday case-fold enable (1 after reset);
// write it only while no text is in flight.
// Reset clears the parser, empties the pipeline and drops m_tvalid.
// When m_tready is low, results hold in the output stages; characters keep
// flowing until a final character finds the pipeline full, then s_tready
// drops until a stage frees up.
`default_nettype none

module weekday_clock_text_parser #(
    parameter int MAX_CHARS   = 39,
    parameter int FRAC_DIGITS = 3
) (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         cfg_we,
    input  wire         cfg_wdata,      // weekday_ignores_case
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [7:0]  s_tdata,        // [7:0] char_code
    input  wire         s_tlast,        // last_char
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [31:0] m_tdata,        // [29:0] week_ms, [31:30] zero
    output logic        m_tuser         // [0] ok
);

    logic        in_valid_reg;
    logic [7:0]  in_char_reg;
    logic        in_last_reg;
    logic        case_fold_reg;
    logic        step;
    logic        snap_ready;
    logic [29:0] week_ms;
    logic        ok;
    wdctp_pkg::parse_snap_t snap;

    // A final character waits for room in the result pipeline
    assign step     = in_valid_reg && (!in_last_reg || snap_ready);
    assign s_tready = !in_valid_reg || step;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_valid_reg  <= 1'b0;
            case_fold_reg <= 1'b1;
        end
        else begin
            if (s_tready)
                in_valid_reg <= s_tvalid;
            if (cfg_we)
                case_fold_reg <= cfg_wdata;
        end
    end

    // Capture the character of each accepted transaction
    always_ff @(posedge clk)
    begin
        if (s_tready) begin
            in_char_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    wdctp_parser #(
        .MAX_CHARS   (MAX_CHARS),
        .FRAC_DIGITS (FRAC_DIGITS)
    ) u_parser (
        .clk         (clk),
        .rst_n       (rst_n),
        .ignore_case (case_fold_reg),
        .step        (step),
        .char_code   (in_char_reg),
        .last_char   (in_last_reg),
        .snap        (snap)
    );

    wdctp_sum u_sum (
        .clk        (clk),
        .rst_n      (rst_n),
        .snap_valid (in_valid_reg && in_last_reg),
        .snap_ready (snap_ready),
        .snap       (snap),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .week_ms    (week_ms),
        .ok         (ok)
    );

    assign m_tdata = {2'b00, week_ms};
    assign m_tuser = ok;

endmodule

`default_nettype wire

// ===== rtl/wdctp_parser.sv =====
`default_nettype none

module wdctp_parser #(
    parameter int MAX_CHARS   = 39,
    parameter int FRAC_DIGITS = 3
) (
    input  wire                       clk,
    input  wire                       rst_n,
    input  wire                       ignore_case,
    input  wire                       step,
    input  wire [7:0]                 char_code,
    input  wire                       last_char,
    output wdctp_pkg::parse_snap_t    snap
);

    localparam int CW = $clog2(MAX_CHARS + 1);
    localparam int FW = $clog2(FRAC_DIGITS + 1);

    wdctp_pkg::parse_snap_t st_reg, st_next, st;
    logic [6:0]    mask_reg, mask_next, mask;
    logic [1:0]    npos_reg, npos_next, npos;
    logic [FW-1:0] fdig_reg, fdig_next, fdig;
    logic [CW-1:0] ccount_reg, ccount_next, ccount;
    logic          is_digit;
    logic [3:0]    dval;
    logic          do_day;
    logic [7:0]    cfold;

    assign is_digit = char_code inside {[wdctp_pkg::ASC_0:wdctp_pkg::ASC_9]};
    assign dval     = 4'(char_code - wdctp_pkg::ASC_0);
    assign cfold    = wdctp_pkg::fold_case(char_code, ignore_case);

    // Apply one character to the parser state
    always_comb
    begin
        st     = st_reg;
        mask   = mask_reg;
        npos   = npos_reg;
        fdig   = fdig_reg;
        ccount = ccount_reg;
        do_day = 1'b0;
        if (st_reg.phase != wdctp_pkg::PH_DONE && ccount_reg < CW'(MAX_CHARS)) begin
            ccount = ccount_reg + CW'(1);
            if (char_code == wdctp_pkg::ASC_NUL) begin
                st = wdctp_pkg::end_of_text(st_reg);
            end
            else begin
                case (st_reg.phase)
                    wdctp_pkg::PH_LEAD:
                    begin
                        if (char_code == wdctp_pkg::ASC_SPACE ||
                            char_code == wdctp_pkg::ASC_TAB) begin
                            st = st_reg;
                        end
                        else if (is_digit) begin
                            st.day   = 3'd0;
                            st.accum = wdctp_pkg::add_digit(8'd0, dval);
                            st.phase = wdctp_pkg::PH_HOUR;
                        end
                        else begin
                            st.phase = wdctp_pkg::PH_DAY;
                            mask     = wdctp_pkg::ALL_DAYS;
                            npos     = 2'd0;
                            do_day   = 1'b1;
                        end
                    end
                    wdctp_pkg::PH_DAY:
                    begin
                        do_day = 1'b1;
                    end
                    wdctp_pkg::PH_PRE_HOUR, wdctp_pkg::PH_PRE_MIN:
                    begin
                        if (char_code == wdctp_pkg::ASC_SPACE) begin
                            st = st_reg;
                        end
                        else if (is_digit) begin
                            st.accum = wdctp_pkg::add_digit(8'd0, dval);
                            st.phase = (st_reg.phase == wdctp_pkg::PH_PRE_HOUR) ?
                                       wdctp_pkg::PH_HOUR : wdctp_pkg::PH_MIN;
                        end
                        else begin
                            st.err   = 1'b1;
                            st.phase = wdctp_pkg::PH_DONE;
                        end
                    end
                    wdctp_pkg::PH_HOUR, wdctp_pkg::PH_HOUR_JUNK:
                    begin
                        if (char_code == wdctp_pkg::ASC_COLON ||
                            char_code == wdctp_pkg::ASC_SPACE) begin
                            if (st_reg.accum > wdctp_pkg::HOUR_MAX) begin
                                st.err   = 1'b1;
                                st.phase = wdctp_pkg::PH_DONE;
                            end
                            else begin
                                st.hour  = st_reg.accum[4:0];
                                st.phase = wdctp_pkg::PH_PRE_MIN;
                            end
                        end
                        else if (st_reg.phase == wdctp_pkg::PH_HOUR && is_digit) begin
                            st.accum = wdctp_pkg::add_digit(st_reg.accum, dval);
                        end
                        else begin
                            st.phase = wdctp_pkg::PH_HOUR_JUNK;
                        end
                    end
                    wdctp_pkg::PH_MIN, wdctp_pkg::PH_MIN_JUNK:
                    begin
                        if (char_code == wdctp_pkg::ASC_COLON ||
                            char_code == wdctp_pkg::ASC_SPACE) begin
                            st   = wdctp_pkg::take_minute(st_reg);
                            fdig = '0;
                        end
                        else if (st_reg.phase == wdctp_pkg::PH_MIN && is_digit) begin
                            st.accum = wdctp_pkg::add_digit(st_reg.accum, dval);
                        end
                        else begin
                            st.phase = wdctp_pkg::PH_MIN_JUNK;
                        end
                    end
                    wdctp_pkg::PH_PRE_SEC:
                    begin
                        if (char_code == wdctp_pkg::ASC_SPACE) begin
                            st = st_reg;
                        end
                        else if (is_digit) begin
                            st.accum = wdctp_pkg::add_digit(8'd0, dval);
                            st.phase = wdctp_pkg::PH_SEC;
                        end
                        else begin
                            st.sec_ms = 16'd0;
                            st.phase  = wdctp_pkg::PH_DONE;
                        end
                    end
                    wdctp_pkg::PH_SEC:
                    begin
                        if (char_code == wdctp_pkg::ASC_SPACE)
                            st = wdctp_pkg::finish_seconds(st_reg);
                        else if (is_digit)
                            st.accum = wdctp_pkg::add_digit(st_reg.accum, dval);
                        else if (char_code == wdctp_pkg::ASC_DOT)
                            st.phase = wdctp_pkg::PH_SEC_FRAC;
                        else
                            st.phase = wdctp_pkg::PH_SEC_JUNK;
                    end
                    wdctp_pkg::PH_SEC_FRAC:
                    begin
                        if (char_code == wdctp_pkg::ASC_SPACE) begin
                            st = wdctp_pkg::finish_seconds(st_reg);
                        end
                        else if (is_digit) begin
                            if (fdig_reg < FW'(FRAC_DIGITS)) begin
                                st.sec_ms = st_reg.sec_ms + 16'(11'(dval) *
                                            11'(wdctp_pkg::frac_weight(2'(fdig_reg))));
                                fdig = fdig_reg + FW'(1);
                            end
                        end
                        else begin
                            st.phase = wdctp_pkg::PH_SEC_JUNK;
                        end
                    end
                    wdctp_pkg::PH_SEC_JUNK:
                    begin
                        if (char_code == wdctp_pkg::ASC_SPACE)
                            st = wdctp_pkg::finish_seconds(st_reg);
                    end
                    default:
                    begin
                        st = st_reg;
                    end
                endcase

                // Weekday token: close on space, else narrow the candidates
                if (do_day) begin
                    if (char_code == wdctp_pkg::ASC_SPACE) begin
                        if (npos < 2'd3 || mask == 7'd0) begin
                            st.err   = 1'b1;
                            st.phase = wdctp_pkg::PH_DONE;
                        end
                        else begin
                            st.day   = wdctp_pkg::first_day(mask);
                            st.phase = wdctp_pkg::PH_PRE_HOUR;
                        end
                    end
                    else if (npos < 2'd3) begin
                        for (int d = 0; d < 7; d++)
                            if (wdctp_pkg::fold_case(wdctp_pkg::day_letter(3'(d), npos),
                                                     ignore_case) != cfold)
                                mask[d] = 1'b0;
                        npos = npos + 2'd1;
                    end
                end
            end
        end
    end

    assign snap = st;

    // Advance on each character; clear after the last one
    always_comb
    begin
        st_next     = st_reg;
        mask_next   = mask_reg;
        npos_next   = npos_reg;
        fdig_next   = fdig_reg;
        ccount_next = ccount_reg;
        if (step) begin
            if (last_char) begin
                st_next     = wdctp_pkg::SNAP_CLEAR;
                mask_next   = wdctp_pkg::ALL_DAYS;
                npos_next   = 2'd0;
                fdig_next   = '0;
                ccount_next = '0;
            end
            else begin
                st_next     = st;
                mask_next   = mask;
                npos_next   = npos;
                fdig_next   = fdig;
                ccount_next = ccount;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            st_reg     <= wdctp_pkg::SNAP_CLEAR;
            mask_reg   <= wdctp_pkg::ALL_DAYS;
            npos_reg   <= 2'd0;
            fdig_reg   <= '0;
            ccount_reg <= '0;
        end
        else begin
            st_reg     <= st_next;
            mask_reg   <= mask_next;
            npos_reg   <= npos_next;
            fdig_reg   <= fdig_next;
            ccount_reg <= ccount_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/wdctp_sum.sv =====
`default_nettype none

module wdctp_sum (
    input  wire                       clk,
    input  wire                       rst_n,
    input  wire                       snap_valid,
    output logic                      snap_ready,
    input  wire wdctp_pkg::parse_snap_t snap,
    output logic                      out_valid,
    input  wire                       out_ready,
    output logic [29:0]               week_ms,
    output logic                      ok
);

    logic a_valid_reg, b_valid_reg, c_valid_reg, o_valid_reg;
    logic a_rdy, b_rdy, c_rdy, o_adv;
    wdctp_pkg::parse_snap_t a_snap_reg, b_snap_reg, b_snap_next;
    logic [29:0] c_hi_reg, c_hi_next, c_lo_reg, c_lo_next;
    logic        c_ok_reg;
    logic [29:0] o_ms_reg;
    logic        o_ok_reg;

    // Stage readiness, back from the output register
    assign o_adv      = !o_valid_reg || out_ready;
    assign c_rdy      = !c_valid_reg || o_adv;
    assign b_rdy      = !b_valid_reg || c_rdy;
    assign a_rdy      = !a_valid_reg || b_rdy;
    assign snap_ready = a_rdy;

    // Close the text, then form the two partial sums
    assign b_snap_next = wdctp_pkg::end_of_text(a_snap_reg);
    assign c_hi_next   = b_snap_reg.err ? 30'd0 :
                         30'(b_snap_reg.day) * wdctp_pkg::DAY_MS +
                         30'(b_snap_reg.hour) * wdctp_pkg::HOUR_MS;
    assign c_lo_next   = b_snap_reg.err ? 30'd0 :
                         30'(b_snap_reg.minute) * wdctp_pkg::MIN_MS +
                         30'(b_snap_reg.sec_ms);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
        end
        else begin
            if (a_rdy)
                a_valid_reg <= snap_valid;
            if (b_rdy)
                b_valid_reg <= a_valid_reg;
            if (c_rdy)
                c_valid_reg <= b_valid_reg;
            if (o_adv)
                o_valid_reg <= c_valid_reg;
        end
    end

    // Payload moves with its stage
    always_ff @(posedge clk)
    begin
        if (a_rdy)
            a_snap_reg <= snap;
        if (b_rdy)
            b_snap_reg <= b_snap_next;
        if (c_rdy) begin
            c_hi_reg <= c_hi_next;
            c_lo_reg <= c_lo_next;
            c_ok_reg <= !b_snap_reg.err;
        end
        if (o_adv) begin
            o_ms_reg <= c_hi_reg + c_lo_reg;
            o_ok_reg <= c_ok_reg;
        end
    end

    assign out_valid = o_valid_reg;
    assign week_ms   = o_ms_reg;
    assign ok        = o_ok_reg;

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
`timescale 1ns / 100ps

module tb;

    localparam int MAX_TEXT      = 39;
    localparam int FRAC_LIMIT    = 3;
    localparam int CYCLE_LIMIT   = 300000;
    localparam int SETTLE_CYCLES = 10;
    localparam int DRAIN_CYCLES  = 20;
    localparam int LONG_HOLD     = 300;

    // Three-letter weekday names, Sunday first, first letter in the top byte
    localparam logic [167:0] DAY_LETTERS = "SunMonTueWedThuFriSat";

    typedef struct packed {
        logic [29:0] week_ms;
        logic        ok;
    } week_time_t;

    function automatic logic [7:0] name_letter(input int d, input int pos);
        return DAY_LETTERS[8 * (20 - 3 * d - pos) +: 8];
    endfunction

    // Track the parser and hold the week times still owed by the block
    class week_time_board;
        bit          fold_on;
        logic [3:0]  phase;
        logic [6:0]  days_left;
        logic [1:0]  name_pos;
        logic [2:0]  day;
        logic [7:0]  acc;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [15:0] sec_ms;
        logic [1:0]  frac_cnt;
        logic [5:0]  n_chars;
        bit          err;
        week_time_t  week_times_due[$];
        int          errors;

        function new();
            fold_on = 1'b1;
            errors  = 0;
            restart();
        endfunction

        function void restart();
            phase     = wdctp_pkg::PH_LEAD;
            days_left = wdctp_pkg::ALL_DAYS;
            name_pos  = 2'd0;
            day       = 3'd0;
            acc       = 8'd0;
            hour      = 5'd0;
            minute    = 6'd0;
            sec_ms    = 16'd0;
            frac_cnt  = 2'd0;
            n_chars   = 6'd0;
            err       = 1'b0;
        endfunction

        function int pending();
            return week_times_due.size();
        endfunction

        function logic [7:0] folded(logic [7:0] c);
            if (fold_on && c >= wdctp_pkg::ASC_A && c <= wdctp_pkg::ASC_Z)
                return c | wdctp_pkg::CASE_BIT;
            return c;
        endfunction

        function bit is_num(logic [7:0] c);
            return c >= wdctp_pkg::ASC_0 && c <= wdctp_pkg::ASC_9;
        endfunction

        function void give_up();
            err   = 1'b1;
            phase = wdctp_pkg::PH_DONE;
        endfunction

        // Append a decimal digit, saturating at 255
        function void push_digit(logic [7:0] c);
            int unsigned v;
            v = int'(acc) * 10 + int'(c) - int'(wdctp_pkg::ASC_0);
            acc = (v > 255) ? 8'd255 : v[7:0];
        endfunction

        function void open_field(logic [3:0] next_phase, logic [7:0] c);
            acc = 8'd0;
            push_digit(c);
            phase = next_phase;
        endfunction

        function void close_minute();
            if (acc > 8'd59)
                give_up();
            else
            begin
                minute   = acc[5:0];
                sec_ms   = 16'd0;
                frac_cnt = 2'd0;
                phase    = wdctp_pkg::PH_PRE_SEC;
            end
        endfunction

        function void close_seconds();
            if (acc >= 8'd60)
                give_up();
            else
            begin
                sec_ms = sec_ms + acc * 16'd1000;
                phase  = wdctp_pkg::PH_DONE;
            end
        endfunction

        // Narrow the candidate days; a space closes the token
        function void name_char(logic [7:0] c);
            int d;
            if (c == wdctp_pkg::ASC_SPACE)
            begin
                if (name_pos < 2'd3 || days_left == 7'd0)
                begin
                    give_up();
                    return;
                end
                day = 3'd0;
                for (d = 6; d >= 0; d--)
                    if (days_left[d])
                        day = d[2:0];
                phase = wdctp_pkg::PH_PRE_HOUR;
                return;
            end
            if (name_pos < 2'd3)
            begin
                for (d = 0; d < 7; d++)
                    if (folded(name_letter(d, name_pos)) != folded(c))
                        days_left[d] = 1'b0;
                name_pos = name_pos + 2'd1;
            end
        endfunction

        // Settle whatever field is open when the text ends
        function void close_text();
            case (phase)
                wdctp_pkg::PH_MIN, wdctp_pkg::PH_MIN_JUNK:
                begin
                    close_minute();
                    if (!err)
                        phase = wdctp_pkg::PH_DONE;
                end
                wdctp_pkg::PH_PRE_SEC:
                begin
                    sec_ms = 16'd0;
                    phase  = wdctp_pkg::PH_DONE;
                end
                wdctp_pkg::PH_SEC, wdctp_pkg::PH_SEC_FRAC, wdctp_pkg::PH_SEC_JUNK:
                    close_seconds();
                wdctp_pkg::PH_DONE:
                    err = err;
                default:
                    give_up();
            endcase
        endfunction

        function void eat_char(logic [7:0] c);
            logic [15:0] weight;
            case (phase)
                wdctp_pkg::PH_LEAD:
                begin
                    if (c != wdctp_pkg::ASC_SPACE && c != wdctp_pkg::ASC_TAB)
                    begin
                        if (is_num(c))
                        begin
                            day = 3'd0;
                            open_field(wdctp_pkg::PH_HOUR, c);
                        end
                        else
                        begin
                            phase     = wdctp_pkg::PH_DAY;
                            days_left = wdctp_pkg::ALL_DAYS;
                            name_pos  = 2'd0;
                            name_char(c);
                        end
                    end
                end
                wdctp_pkg::PH_DAY:
                    name_char(c);
                wdctp_pkg::PH_PRE_HOUR:
                begin
                    if (c != wdctp_pkg::ASC_SPACE)
                    begin
                        if (is_num(c))
                            open_field(wdctp_pkg::PH_HOUR, c);
                        else
                            give_up();
                    end
                end
                wdctp_pkg::PH_HOUR, wdctp_pkg::PH_HOUR_JUNK:
                begin
                    if (c == wdctp_pkg::ASC_COLON || c == wdctp_pkg::ASC_SPACE)
                    begin
                        if (acc > 8'd23)
                            give_up();
                        else
                        begin
                            hour  = acc[4:0];
                            phase = wdctp_pkg::PH_PRE_MIN;
                        end
                    end
                    else if (phase == wdctp_pkg::PH_HOUR && is_num(c))
                        push_digit(c);
                    else
                        phase = wdctp_pkg::PH_HOUR_JUNK;
                end
                wdctp_pkg::PH_PRE_MIN:
                begin
                    if (c != wdctp_pkg::ASC_SPACE)
                    begin
                        if (is_num(c))
                            open_field(wdctp_pkg::PH_MIN, c);
                        else
                            give_up();
                    end
                end
                wdctp_pkg::PH_MIN, wdctp_pkg::PH_MIN_JUNK:
                begin
                    if (c == wdctp_pkg::ASC_COLON || c == wdctp_pkg::ASC_SPACE)
                        close_minute();
                    else if (phase == wdctp_pkg::PH_MIN && is_num(c))
                        push_digit(c);
                    else
                        phase = wdctp_pkg::PH_MIN_JUNK;
                end
                wdctp_pkg::PH_PRE_SEC:
                begin
                    if (c != wdctp_pkg::ASC_SPACE)
                    begin
                        if (is_num(c))
                            open_field(wdctp_pkg::PH_SEC, c);
                        else
                        begin
                            sec_ms = 16'd0;
                            phase  = wdctp_pkg::PH_DONE;
                        end
                    end
                end
                wdctp_pkg::PH_SEC:
                begin
                    if (c == wdctp_pkg::ASC_SPACE)
                        close_seconds();
                    else if (is_num(c))
                        push_digit(c);
                    else if (c == wdctp_pkg::ASC_DOT)
                        phase = wdctp_pkg::PH_SEC_FRAC;
                    else
                        phase = wdctp_pkg::PH_SEC_JUNK;
                end
                wdctp_pkg::PH_SEC_FRAC:
                begin
                    if (c == wdctp_pkg::ASC_SPACE)
                        close_seconds();
                    else if (is_num(c))
                    begin
                        // drop digits past the millisecond place
                        if (frac_cnt < FRAC_LIMIT)
                        begin
                            case (frac_cnt)
                                2'd0:    weight = 16'd100;
                                2'd1:    weight = 16'd10;
                                default: weight = 16'd1;
                            endcase
                            sec_ms   = sec_ms + (c - wdctp_pkg::ASC_0) * weight;
                            frac_cnt = frac_cnt + 2'd1;
                        end
                    end
                    else
                        phase = wdctp_pkg::PH_SEC_JUNK;
                end
                wdctp_pkg::PH_SEC_JUNK:
                begin
                    if (c == wdctp_pkg::ASC_SPACE)
                        close_seconds();
                end
                default:
                    err = err;
            endcase
        endfunction

        // Advance on one accepted character; queue a week time on the last one
        function void note_char(logic [7:0] c, bit last);
            week_time_t  due;
            int unsigned total;
            if (phase != wdctp_pkg::PH_DONE && n_chars < MAX_TEXT)
            begin
                n_chars = n_chars + 6'd1;
                if (c == wdctp_pkg::ASC_NUL)
                    close_text();
                else
                    eat_char(c);
            end
            if (!last)
                return;
            close_text();
            total = 0;
            if (!err)
                total = day * 86400000 + hour * 3600000 + minute * 60000 + sec_ms;
            due.week_ms = total[29:0];
            due.ok      = !err;
            week_times_due.push_back(due);
            restart();
        endfunction

        function void compare_week_time(logic [29:0] week_ms, logic ok);
            week_time_t due;
            if (week_times_due.size() == 0)
            begin
                $error("unexpected result: week_ms %0d ok %0b", week_ms, ok);
                errors++;
                return;
            end
            due = week_times_due.pop_front();
            if (week_ms !== due.week_ms)
            begin
                $error("week_ms: expected %0d, actual %0d", due.week_ms, week_ms);
                errors++;
            end
            if (ok !== due.ok)
            begin
                $error("ok: expected %0b, actual %0b", due.ok, ok);
                errors++;
            end
        endfunction
    endclass

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        cfg_we    = 1'b0;
    logic        cfg_wdata = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata   = 8'd0;   // [7:0] char_code
    logic        s_tlast   = 1'b0;   // last_char
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [31:0] m_tdata;            // [29:0] week_ms
    logic        m_tuser;            // [0] ok

    week_time_board sb = new();
    logic [7:0]     line_buf[$];
    int             chars_sent   = 0;
    int             burst_left   = 0;
    bit             hold_off_req = 1'b0;
    int unsigned    cycle_count  = 0;

    weekday_clock_text_parser dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Mostly short gaps, now and then a long one
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 40);
    endfunction

    // Field value: mostly in range, with the limits, just past them and far past
    function automatic int unsigned field_value(input int unsigned top);
        int r;
        r = $urandom_range(0, 99);
        if (r < 10)
            return top;
        if (r < 20)
            return 0;
        if (r < 85)
            return $urandom_range(0, top);
        if (r < 95)
            return $urandom_range(top + 1, 99);
        return $urandom_range(100, 99999);
    endfunction

    function automatic void add_number(input int unsigned v, input int min_digits);
        string t;
        t = $sformatf("%0d", v);
        while (t.len() < min_digits)
            t = {"0", t};
        for (int i = 0; i < t.len(); i++)
            line_buf.push_back(t[i]);
    endfunction

    function automatic void add_digit_char();
        logic [7:0] ch;
        ch = 8'(wdctp_pkg::ASC_0 + $urandom_range(0, 9));
        line_buf.push_back(ch);
    endfunction

    // Stray marks, exponent and hex letters among them
    function automatic void add_junk();
        logic [7:0] ch;
        case ($urandom_range(0, 5))
            0:       ch = "e";
            1:       ch = "E";
            2:       ch = "x";
            3:       ch = "f";
            4:       ch = "+";
            default: ch = 8'($urandom_range(33, 126));
        endcase
        line_buf.push_back(ch);
    endfunction

    function automatic void add_weekday();
        int         d;
        int         keep;
        int         r;
        logic [7:0] ch;
        d    = $urandom_range(0, 6);
        keep = ($urandom_range(0, 19) == 0) ? $urandom_range(1, 2) : 3;
        for (int pos = 0; pos < keep; pos++)
        begin
            ch = name_letter(d, pos);
            if ($urandom_range(0, 2) == 0)
                ch = ch ^ wdctp_pkg::CASE_BIT;
            if ($urandom_range(0, 11) == 0)
                ch = 8'($urandom_range(65, 122));
            line_buf.push_back(ch);
        end
        // extend to longer tokens such as full day names
        if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 5))
            begin
                ch = 8'($urandom_range(97, 122));
                line_buf.push_back(ch);
            end
        // separate from the hour; a tab stays part of the token
        r = $urandom_range(0, 19);
        if (r == 0)
            line_buf.push_back(wdctp_pkg::ASC_TAB);
        else if (r != 1)
            repeat ($urandom_range(1, 2))
                line_buf.push_back(wdctp_pkg::ASC_SPACE);
    endfunction

    // Well-formed clock text with random content and occasional flaws
    function automatic void build_clock_text();
        logic [7:0] ch;
        line_buf.delete();
        if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 3))
                line_buf.push_back(($urandom_range(0, 3) == 0) ?
                                   wdctp_pkg::ASC_TAB : wdctp_pkg::ASC_SPACE);
        if ($urandom_range(0, 9) < 7)
            add_weekday();
        if ($urandom_range(0, 29) != 0)
            add_number(field_value(23), $urandom_range(1, 2));
        if ($urandom_range(0, 19) == 0)
            add_junk();
        line_buf.push_back(($urandom_range(0, 9) == 0) ?
                           wdctp_pkg::ASC_SPACE : wdctp_pkg::ASC_COLON);
        if ($urandom_range(0, 9) == 0)
            line_buf.push_back(wdctp_pkg::ASC_SPACE);
        if ($urandom_range(0, 29) != 0)
            add_number(field_value(59), $urandom_range(1, 2));
        if ($urandom_range(0, 19) == 0)
            add_junk();
        // seconds with an optional fraction
        if ($urandom_range(0, 2) != 0)
        begin
            line_buf.push_back(($urandom_range(0, 9) == 0) ?
                               wdctp_pkg::ASC_SPACE : wdctp_pkg::ASC_COLON);
            if ($urandom_range(0, 19) == 0)
                add_junk();
            else
                add_number(field_value(59), $urandom_range(1, 2));
            if ($urandom_range(0, 19) == 0)
                add_junk();
            if ($urandom_range(0, 4) < 3)
            begin
                line_buf.push_back(wdctp_pkg::ASC_DOT);
                repeat ($urandom_range(0, 5))
                    add_digit_char();
                if ($urandom_range(0, 19) == 0)
                    add_junk();
            end
        end
        // trailing words after the clock
        if ($urandom_range(0, 9) == 0)
        begin
            line_buf.push_back(wdctp_pkg::ASC_SPACE);
            repeat ($urandom_range(0, 4))
            begin
                ch = 8'($urandom_range(32, 126));
                line_buf.push_back(ch);
            end
        end
        if ($urandom_range(0, 29) == 0)
            line_buf.insert($urandom_range(0, line_buf.size() - 1), wdctp_pkg::ASC_NUL);
    endfunction

    function automatic void build_text();
        int         r;
        int         k;
        logic [7:0] ch;
        r = $urandom_range(0, 99);
        if (r < 65)
            build_clock_text();
        else if (r < 75)
        begin
            // cut a clock text short
            build_clock_text();
            k = $urandom_range(1, line_buf.size());
            while (line_buf.size() > k)
                void'(line_buf.pop_back());
        end
        else if (r < 83)
        begin
            // push the text against or past the character limit
            build_clock_text();
            if ($urandom_range(0, 1) == 0)
                k = MAX_TEXT - line_buf.size() + $urandom_range(0, 2) - 1;
            else
                k = $urandom_range(25, 40);
            repeat (k)
                line_buf.push_front(wdctp_pkg::ASC_SPACE);
            repeat ($urandom_range(0, 6))
            begin
                ch = 8'($urandom_range(0, 255));
                line_buf.push_back(ch);
            end
        end
        else if (r < 95)
        begin
            // noise from the parser's alphabet and any byte
            line_buf.delete();
            repeat ($urandom_range(1, 12))
            begin
                case ($urandom_range(0, 9))
                    0, 1, 2: ch = 8'(wdctp_pkg::ASC_0 + $urandom_range(0, 9));
                    3:       ch = wdctp_pkg::ASC_COLON;
                    4:       ch = wdctp_pkg::ASC_SPACE;
                    5:       ch = wdctp_pkg::ASC_DOT;
                    6:       ch = wdctp_pkg::ASC_TAB;
                    7:       ch = name_letter($urandom_range(0, 6), $urandom_range(0, 2));
                    8:       ch = wdctp_pkg::ASC_NUL;
                    default: ch = 8'($urandom_range(0, 255));
                endcase
                line_buf.push_back(ch);
            end
        end
        else
        begin
            // empty, blank or one-character text
            line_buf.delete();
            case ($urandom_range(0, 3))
                0:       ch = wdctp_pkg::ASC_SPACE;
                1:       ch = wdctp_pkg::ASC_NUL;
                2:       ch = wdctp_pkg::ASC_TAB;
                default: ch = 8'(wdctp_pkg::ASC_0 + $urandom_range(0, 9));
            endcase
            line_buf.push_back(ch);
        end
    endfunction

    // Offer one character and hold it until the block takes it
    task automatic send_char(input logic [7:0] code, input bit is_last);
        int gap;
        gap = (burst_left > 0) ? 0 : idle_len();
        if (burst_left > 0)
            burst_left--;
        @(negedge clk);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= code;
        s_tlast  <= is_last;
        @(posedge clk);
        while (s_tready !== 1'b1)
            @(posedge clk);
        sb.note_char(code, is_last);
    endtask

    task automatic send_text();
        int n;
        if ($urandom_range(0, 19) == 0)
            burst_left = $urandom_range(20, 80);
        n = line_buf.size();
        for (int i = 0; i < n; i++)
            send_char(line_buf[i], i == n - 1);
        chars_sent += n;
    endtask

    task automatic send_string(input string t);
        line_buf.delete();
        for (int i = 0; i < t.len(); i++)
            line_buf.push_back(t[i]);
        send_text();
    endtask

    task automatic run_random(input int target);
        while (chars_sent < target)
        begin
            build_text();
            send_text();
        end
    endtask

    // Drop valid, wait for every owed result, then let the pipeline drain
    task automatic settle_parser();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_case_fold(input bit fold);
        settle_parser();
        cfg_we    <= 1'b1;
        cfg_wdata <= fold;
        @(negedge clk);
        cfg_we    <= 1'b0;
        sb.fold_on = fold;
    endtask

    // Stall the result side at random, with calm stretches and one long hold
    initial
    begin : result_sink
        int stall_left;
        int mode_left;
        int hold_left;
        bit calm;
        stall_left = 0;
        mode_left  = 0;
        hold_left  = 0;
        calm       = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_off_req)
            begin
                hold_off_req = 1'b0;
                hold_left    = LONG_HOLD;
                m_tready    <= 1'b0;
            end
            else if (hold_left > 0)
                hold_left--;
            else
            begin
                if (mode_left == 0)
                begin
                    calm      = ($urandom_range(0, 3) == 0);
                    mode_left = $urandom_range(50, 200);
                end
                mode_left--;
                if (stall_left > 0)
                begin
                    stall_left--;
                    m_tready <= 1'b0;
                end
                else
                begin
                    m_tready <= 1'b1;
                    if (!calm)
                        stall_left = idle_len();
                end
            end
        end
    end

    // Check each result transaction against the oldest owed week time
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.compare_week_time(m_tdata[29:0], m_tuser);
    end

    always @(posedge clk)
        cycle_count <= cycle_count + 1;

    initial
    begin : watchdog
        wait (cycle_count >= CYCLE_LIMIT);
        $display("[weekday_clock_text_parser] ERROR");
        $finish;
    end

    initial
    begin : stimulus
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;

        // largest time of week, smallest time, folded day name
        send_string("Sat 23:59:59.999");
        send_string("0:00");
        send_string("sUN 0:0:0");

        write_case_fold(1'b0);
        run_random(450);

        // hold the result side while characters keep coming
        write_case_fold(1'b1);
        hold_off_req = 1'b1;
        burst_left   = 300;
        run_random(900);

        write_case_fold(1'b0);
        run_random(1150);

        write_case_fold(1'b1);
        run_random(1350);

        settle_parser();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("[weekday_clock_text_parser] OK");
        else
            $display("[weekday_clock_text_parser] ERROR");
        $finish;
    end

endmodule
